### sv/selective_repeat_sender_window_core_assert.svh
// Assertion macros shared by the window core.
// Each expects signals named clk and rst_n in the enclosing module.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_CORE_ASSERT_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_CORE_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication.
`define SRSW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SRSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SRSW_ASSERT_NOW(lbl, ante, cons, msg)
`define SRSW_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### sv/srsw_pkg.sv
`timescale 1ns / 1ps

package srsw_pkg;

  // Sequence space is a power of two, so sequence arithmetic wraps in SEQ_W bits.
  localparam int SEQ_SPACE    = 8;
  localparam int SEQ_W        = 3;
  localparam int PAYLOAD_BITS = 32;
  localparam int WIN_W        = 3;

  localparam logic [SEQ_W-1:0] SEQ_ONE    = 1;
  localparam logic [WIN_W-1:0] WIN_ONE    = 1;
  localparam logic [WIN_W-1:0] WIN_ZERO   = 0;
  localparam logic [WIN_W-1:0] WIN_RESET  = 4;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [1:0] {
    CMD_SEND    = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OCC,
    S_CMD,
    S_SLIDE,
    S_READ,
    S_FIN
  } state_t;

  typedef struct packed {
    logic                    accepted;
    logic                    packet_valid;
    logic [SEQ_W-1:0]        packet_seq;
    logic [PAYLOAD_BITS-1:0] packet_payload;
    logic                    timer_start;
    logic                    timer_stop;
    logic [SEQ_W-1:0]        timer_index;
  } res_t;

endpackage

### sv/srsw_ram.sv
`timescale 1ns / 1ps

module srsw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/selective_repeat_sender_window_core.sv
`timescale 1ns / 1ps
// Sender window of a selective-repeat ARQ link. Each input transfer carries a command in
// in_tuser (send, acknowledgment, timer expiry) and one result transfer comes back per
// command, reporting the packet to emit, the timer action and the window status after the
// step. From acceptance, a send, an ignored command or an acknowledgment that marks
// nothing passes through states OCC, CMD and FIN to the result register; a timer expiry
// adds READ for the registered payload buffer read; an acknowledgment that marks an entry
// adds SLIDE, sliding the base past the consecutive marked entries, one entry per cycle.
// A small sequencer runs these states and a single shared modulo-subtract-and-compare
// unit once per step. in_tready is high only while the sequencer is idle; a finished
// result sits in the output register, so the next command is taken while that result still
// waits for out_tready. The user must write window_size through cfg_wr_en/cfg_wr_data
// only while no command is in flight, unenforced by the block; 0 acts as a window of one.

`include "selective_repeat_sender_window_core_assert.svh"

module selective_repeat_sender_window_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // Command channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // seq_number[2:0], ack_intact[3], payload[35:4], zero fill [39:36]
  input  logic [srsw_pkg::IN_DATA_W-1:0]     in_tdata,
  // command[1:0]
  input  logic [srsw_pkg::IN_USER_W-1:0]     in_tuser,
  // Result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // accepted[0], packet_valid[1], packet_seq[4:2], packet_payload[36:5], timer_start[37],
  // timer_stop[38], timer_index[41:39], window_full[42], window_base[45:43],
  // next_sequence[48:46], zero fill [55:49]
  output logic [srsw_pkg::OUT_DATA_W-1:0]    out_tdata,
  // Configuration: window_size
  input  logic                               cfg_wr_en,
  input  logic [srsw_pkg::WIN_W-1:0]         cfg_wr_data
);

  localparam int SW = srsw_pkg::SEQ_W;
  localparam int PW = srsw_pkg::PAYLOAD_BITS;

  srsw_pkg::state_t state_r, state_nxt;

  // Latched command
  srsw_pkg::cmd_t   cmd_r,    cmd_nxt;
  logic [SW-1:0]    seq_r,    seq_nxt;
  logic             intact_r, intact_nxt;
  logic [PW-1:0]    pay_r,    pay_nxt;

  // Window state
  logic [SW-1:0]                     base_r,  base_nxt;
  logic [SW-1:0]                     next_r,  next_nxt;
  logic [srsw_pkg::SEQ_SPACE-1:0]    marks_r, marks_nxt;
  logic [srsw_pkg::WIN_W-1:0]        window_size_r;

  // Per-command scratch
  logic [SW-1:0]    occ_r,  occ_nxt;
  logic             room_r, room_nxt;
  srsw_pkg::res_t   res_r,  res_nxt;

  // Output register
  logic                            out_valid_r, out_valid_nxt;
  logic [srsw_pkg::OUT_DATA_W-1:0] out_data_r,  out_data_nxt;

  // Shared unit: modulo subtract, then compare against a selected bound
  logic [SW-1:0]                 sub_a, sub_b, diff;
  logic [srsw_pkg::WIN_W-1:0]    cmp_b;
  logic                          cmp_lt;
  logic [srsw_pkg::WIN_W-1:0]    eff_window;

  // Payload buffer
  logic           ram_we;
  logic [PW-1:0]  ram_rdata;

  logic in_xfer;
  logic out_free;
  logic slide_go;

  assign in_tready  = (state_r == srsw_pkg::S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A zero window behaves as one; the 3-bit register cannot exceed SEQ_SPACE-1.
  assign eff_window = (window_size_r == srsw_pkg::WIN_ZERO) ? srsw_pkg::WIN_ONE
                                                            : window_size_r;

  // Operand select: distance of the acked number from base while deciding the command,
  // outstanding count (next - base) everywhere else.
  always_comb begin
    sub_a = (state_r == srsw_pkg::S_CMD) ? seq_r : next_r;
    sub_b = base_r;
    cmp_b = (state_r == srsw_pkg::S_CMD) ? occ_r : eff_window;
  end

  assign diff   = sub_a - sub_b;
  assign cmp_lt = (diff < cmp_b);

  // Advance base while the entry under it is marked and it has not reached next.
  assign slide_go = (base_r != next_r) && marks_r[base_r];

  srsw_ram #(
    .WIDTH (PW),
    .DEPTH (srsw_pkg::SEQ_SPACE)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (next_r),
    .wdata (pay_r),
    .raddr (seq_r),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srsw_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_nxt = srsw_pkg::S_OCC;
        end
      end
      srsw_pkg::S_OCC: begin
        state_nxt = srsw_pkg::S_CMD;
      end
      srsw_pkg::S_CMD: begin
        if (cmd_r == srsw_pkg::CMD_ACK && intact_r && cmp_lt) begin
          state_nxt = srsw_pkg::S_SLIDE;
        end else if (cmd_r == srsw_pkg::CMD_TIMEOUT) begin
          state_nxt = srsw_pkg::S_READ;
        end else begin
          state_nxt = srsw_pkg::S_FIN;
        end
      end
      srsw_pkg::S_SLIDE: begin
        if (!slide_go) begin
          state_nxt = srsw_pkg::S_FIN;
        end
      end
      srsw_pkg::S_READ: begin
        state_nxt = srsw_pkg::S_FIN;
      end
      srsw_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = srsw_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = srsw_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath updates per state
  always_comb begin
    cmd_nxt       = cmd_r;
    seq_nxt       = seq_r;
    intact_nxt    = intact_r;
    pay_nxt       = pay_r;
    base_nxt      = base_r;
    next_nxt      = next_r;
    marks_nxt     = marks_r;
    occ_nxt       = occ_r;
    room_nxt      = room_r;
    res_nxt       = res_r;
    ram_we        = 1'b0;
    out_data_nxt  = out_data_r;
    // Drop the result once the consumer takes it
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      srsw_pkg::S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt    = srsw_pkg::cmd_t'(in_tuser);
          seq_nxt    = in_tdata[2:0];
          intact_nxt = in_tdata[3];
          pay_nxt    = in_tdata[35:4];
          res_nxt    = '0;
        end
      end
      srsw_pkg::S_OCC: begin
        // Outstanding count and room for a send
        occ_nxt  = diff;
        room_nxt = cmp_lt;
      end
      srsw_pkg::S_CMD: begin
        unique case (cmd_r)
          srsw_pkg::CMD_SEND: begin
            if (room_r) begin
              ram_we                 = 1'b1;
              res_nxt.accepted       = 1'b1;
              res_nxt.packet_valid   = 1'b1;
              res_nxt.packet_seq     = next_r;
              res_nxt.packet_payload = pay_r;
              res_nxt.timer_start    = 1'b1;
              res_nxt.timer_index    = next_r;
              next_nxt               = next_r + srsw_pkg::SEQ_ONE;
            end
          end
          srsw_pkg::CMD_ACK: begin
            if (intact_r) begin
              res_nxt.accepted    = 1'b1;
              res_nxt.timer_stop  = 1'b1;
              res_nxt.timer_index = seq_r;
              // Mark only numbers that are outstanding
              if (cmp_lt) begin
                marks_nxt[seq_r] = 1'b1;
              end
            end
          end
          srsw_pkg::CMD_TIMEOUT: begin
            res_nxt.packet_valid = 1'b1;
            res_nxt.packet_seq   = seq_r;
            res_nxt.timer_start  = 1'b1;
            res_nxt.timer_index  = seq_r;
          end
          srsw_pkg::CMD_NONE: begin
          end
          default: begin
          end
        endcase
      end
      srsw_pkg::S_SLIDE: begin
        if (slide_go) begin
          marks_nxt[base_r] = 1'b0;
          base_nxt          = base_r + srsw_pkg::SEQ_ONE;
        end
      end
      srsw_pkg::S_READ: begin
        res_nxt.packet_payload = ram_rdata;
      end
      srsw_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, next_r, base_r, !cmp_lt,
                           res_r.timer_index, res_r.timer_stop, res_r.timer_start,
                           res_r.packet_payload, res_r.packet_seq,
                           res_r.packet_valid, res_r.accepted};
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= srsw_pkg::S_IDLE;
      base_r        <= '0;
      next_r        <= '0;
      marks_r       <= '0;
      window_size_r <= srsw_pkg::WIN_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      marks_r     <= marks_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        window_size_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    seq_r      <= seq_nxt;
    intact_r   <= intact_nxt;
    pay_r      <= pay_nxt;
    occ_r      <= occ_nxt;
    room_r     <= room_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Sequencer holds off new commands for the cycle after one is taken
  `SRSW_ASSERT_NEXT(a_busy_after_take, in_xfer, !in_tready, "in_tready high after a transfer")
  // Slide leaves the base on an unmarked entry
  `SRSW_ASSERT_NOW(a_base_unmarked, state_r == srsw_pkg::S_IDLE, !marks_r[base_r], "base marked when idle")
  // Every emitted packet restarts its timer
  `SRSW_ASSERT_NOW(a_packet_timer, out_valid_r, out_data_r[1] == out_data_r[37], "packet without timer start")
  // A timer is never started and stopped in one result
  `SRSW_ASSERT_NOW(a_timer_excl, out_valid_r, !(out_data_r[37] && out_data_r[38]), "timer start and stop together")

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import srsw_pkg::*;

  // Cycle budget for the whole run.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PLAN_LEN    = 10;
  localparam int unsigned HALF_PHASE  = 42;

  // One command as the sender offers it.
  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    intact;
    logic [SEQ_W-1:0]        seq;
    cmd_t                    cmd;
  } cmd_item_t;

  // One result transfer, laid out so that accepted sits in bit 0 as on out_tdata.
  typedef struct packed {
    logic [SEQ_W-1:0]        next_sequence;
    logic [SEQ_W-1:0]        window_base;
    logic                    window_full;
    logic [SEQ_W-1:0]        timer_index;
    logic                    timer_stop;
    logic                    timer_start;
    logic [PAYLOAD_BITS-1:0] packet_payload;
    logic [SEQ_W-1:0]        packet_seq;
    logic                    packet_valid;
    logic                    accepted;
  } window_report_t;

  // Sender window state: payload buffer, ack marks, base, next number and window size.
  typedef struct packed {
    logic [SEQ_SPACE-1:0][PAYLOAD_BITS-1:0] store;
    logic [SEQ_SPACE-1:0]                   marks;
    logic [SEQ_W-1:0]                       base_seq;
    logic [SEQ_W-1:0]                       next_seq;
    logic [WIN_W-1:0]                       win;
  } window_state_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = CMD_SEND;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [WIN_W-1:0]      cfg_wr_data = WIN_RESET;

  // Two copies of the window: one advanced as commands are queued (steers the stimulus),
  // one advanced as the block accepts them (produces the expected results).
  window_state_t          plan_state;
  window_state_t          live_state;
  cmd_item_t              pending_cmds[$];
  window_report_t         expected_reports[$];
  cmd_item_t              offered;

  int unsigned items_queued  = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_wait     = 0;
  int unsigned recv_wait     = 0;
  int unsigned hold_left     = 0;
  int unsigned holds_done    = 0;
  int unsigned sends_refused = 0;
  int unsigned cmd_tally[4]  = '{0, 0, 0, 0};
  bit          sender_burst   = 1'b0;
  bit          receiver_burst = 1'b0;

  logic [WIN_W-1:0] window_plan[PLAN_LEN] = '{3'd1, 3'd0, 3'd7, 3'd3, 3'd5,
                                              3'd7, 3'd2, 3'd6, 3'd4, 3'd7};

  selective_repeat_sender_window_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // Advance the window by one command and return the result transfer it produces.
  function automatic window_report_t advance_window(inout window_state_t st,
                                                    input cmd_item_t it);
    window_report_t   r;
    logic [SEQ_W-1:0] busy;
    logic [SEQ_W-1:0] ack_dist;
    int unsigned      eff;
    int unsigned      n;
    r    = '0;
    eff  = (st.win == WIN_ZERO) ? 1 : int'(st.win);
    // Sequence space is 8, so 3-bit subtraction is the modular distance.
    busy = st.next_seq - st.base_seq;
    case (it.cmd)
      CMD_SEND: begin
        // Refuse while full; otherwise buffer, emit and start the timer.
        if (busy < eff) begin
          st.store[st.next_seq] = it.payload;
          r.accepted       = 1'b1;
          r.packet_valid   = 1'b1;
          r.packet_seq     = st.next_seq;
          r.packet_payload = it.payload;
          r.timer_start    = 1'b1;
          r.timer_index    = st.next_seq;
          st.next_seq      = st.next_seq + SEQ_ONE;
        end
      end
      CMD_ACK: begin
        // Corrupted acks do nothing; intact ones always stop the timer.
        if (it.intact) begin
          r.accepted    = 1'b1;
          r.timer_stop  = 1'b1;
          r.timer_index = it.seq;
          ack_dist = it.seq - st.base_seq;
          if (ack_dist < busy) begin
            st.marks[it.seq] = 1'b1;
            n = 0;
            while (n < busy && st.marks[st.base_seq]) begin
              st.marks[st.base_seq] = 1'b0;
              st.base_seq = st.base_seq + SEQ_ONE;
              n++;
            end
          end
        end
      end
      CMD_TIMEOUT: begin
        // Replay whatever is buffered, outstanding or not.
        r.packet_valid   = 1'b1;
        r.packet_seq     = it.seq;
        r.packet_payload = st.store[it.seq];
        r.timer_start    = 1'b1;
        r.timer_index    = it.seq;
      end
      default: ;
    endcase
    // Recount outstanding in 3 bits so the difference wraps before the compare.
    busy            = st.next_seq - st.base_seq;
    r.window_full   = (busy >= eff);
    r.window_base   = st.base_seq;
    r.next_sequence = st.next_seq;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 40) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                results_seen, name, got, want));
  endtask

  // Queue one command and run it through the planning copy of the window.
  task automatic queue_cmd(cmd_t c, logic [SEQ_W-1:0] s, logic ok, logic [31:0] pay);
    cmd_item_t      it;
    window_report_t r;
    it.cmd     = c;
    it.seq     = s;
    it.intact  = ok;
    it.payload = pay;
    r = advance_window(plan_state, it);
    if (c == CMD_SEND && !r.accepted) sends_refused++;
    cmd_tally[c]++;
    pending_cmds.push_back(it);
    items_queued++;
  endtask

  // Block until every queued command has produced its result, then let the block settle.
  task automatic wait_idle();
    while (results_seen < items_queued) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write window_size; only called while nothing is in flight.
  task automatic write_window(logic [WIN_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    plan_state.win = v;
    live_state.win = v;
  endtask

  // Mostly sends and acks of numbers that are actually outstanding, so the base keeps
  // sliding; the rest is stray acks, corrupted acks, timeouts and the unused command.
  task automatic random_burst(int unsigned count);
    int unsigned      pick;
    logic [SEQ_W-1:0] busy;
    logic [SEQ_W-1:0] s;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      busy = plan_state.next_seq - plan_state.base_seq;
      s    = $urandom_range(0, SEQ_SPACE - 1);
      if (pick < 45) begin
        queue_cmd(CMD_SEND, s, $urandom_range(0, 1), $urandom);
      end else if (pick < 78) begin
        if (busy != 0) s = plan_state.base_seq + SEQ_W'($urandom_range(0, busy - 1));
        queue_cmd(CMD_ACK, s, 1'b1, $urandom);
      end else if (pick < 86) begin
        queue_cmd(CMD_ACK, s, 1'b1, $urandom);
      end else if (pick < 91) begin
        queue_cmd(CMD_ACK, s, 1'b0, $urandom);
      end else if (pick < 98) begin
        queue_cmd(CMD_TIMEOUT, s, $urandom_range(0, 1), $urandom);
      end else begin
        queue_cmd(CMD_NONE, s, $urandom_range(0, 1), $urandom);
      end
    end
  endtask

  // Sender: present queued commands, predict each one at the edge that transfers it, and
  // wait a drawn number of cycles before offering the next.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= CMD_SEND;
      send_wait = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_reports.push_back(advance_window(live_state, offered));
        send_wait = sender_burst ? 0 : $urandom_range(0, 13);
      end
      // Hold the current offer until it transfers; only then load the next one.
      if (!in_tvalid || in_tready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          offered = pending_cmds.pop_front();
          in_tdata  <= {4'b0, offered.payload, offered.intact, offered.seq};
          in_tuser  <= offered.cmd;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check every result transfer against the oldest expectation, then stall
  // for a drawn number of cycles. At most twice in the run, hold off for a long stretch
  // while commands are still queued so the block backs up and drops in_tready.
  always @(posedge clk) begin
    window_report_t got;
    window_report_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = window_report_t'(out_tdata[48:0]);
        if (expected_reports.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = expected_reports.pop_front();
          compare_field("accepted",       got.accepted,       want.accepted);
          compare_field("packet_valid",   got.packet_valid,   want.packet_valid);
          compare_field("packet_seq",     got.packet_seq,     want.packet_seq);
          compare_field("packet_payload", got.packet_payload, want.packet_payload);
          compare_field("timer_start",    got.timer_start,    want.timer_start);
          compare_field("timer_stop",     got.timer_stop,     want.timer_stop);
          compare_field("timer_index",    got.timer_index,    want.timer_index);
          compare_field("window_full",    got.window_full,    want.window_full);
          compare_field("window_base",    got.window_base,    want.window_base);
          compare_field("next_sequence",  got.next_sequence,  want.next_sequence);
        end
        results_seen++;
        recv_wait = receiver_burst ? 0 : $urandom_range(0, 13);
      end
      if (hold_left == 0 && holds_done < 2 && results_seen >= 250 * (holds_done + 1) &&
          pending_cmds.size() > 8) begin
        hold_left = 220;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if the traffic never drains.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench failed");
    $finish;
  end

  initial begin
    plan_state     = '0;
    plan_state.win = WIN_RESET;
    live_state     = plan_state;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset window of four: extreme payloads, replays, a corrupted ack, the unused
    // command, filling the window, a refused send, acks out of range and out of order.
    queue_cmd(CMD_SEND,    3'd0, 1'b0, 32'h0000_0000);
    queue_cmd(CMD_SEND,    3'd0, 1'b1, 32'hFFFF_FFFF);
    queue_cmd(CMD_TIMEOUT, 3'd0, 1'b0, $urandom);
    queue_cmd(CMD_TIMEOUT, 3'd1, 1'b1, $urandom);
    queue_cmd(CMD_ACK,     3'd1, 1'b0, $urandom);
    queue_cmd(CMD_NONE,    3'd7, 1'b1, 32'hFFFF_FFFF);
    queue_cmd(CMD_SEND,    3'd7, 1'b1, 32'hA5A5_5A5A);
    queue_cmd(CMD_SEND,    3'd5, 1'b0, $urandom);
    queue_cmd(CMD_SEND,    3'd2, 1'b1, $urandom);
    queue_cmd(CMD_ACK,     3'd5, 1'b1, $urandom);
    queue_cmd(CMD_ACK,     3'd1, 1'b1, $urandom);
    queue_cmd(CMD_ACK,     3'd0, 1'b1, $urandom);
    queue_cmd(CMD_ACK,     3'd1, 1'b1, $urandom);
    queue_cmd(CMD_ACK,     3'd3, 1'b1, $urandom);
    wait_idle();

    // Widest window: fill all seven slots across the wrap, refuse one more, then an
    // ack at the base slides past an entry marked earlier.
    write_window(3'd7);
    repeat (5) queue_cmd(CMD_SEND, $urandom_range(0, 7), $urandom_range(0, 1), $urandom);
    queue_cmd(CMD_SEND,    3'd6, 1'b1, $urandom);
    queue_cmd(CMD_ACK,     3'd2, 1'b1, $urandom);
    queue_cmd(CMD_TIMEOUT, 3'd7, 1'b0, $urandom);
    wait_idle();

    // Every slot has been written by now, so replays of any number are legal.
    for (int unsigned p = 0; p < PLAN_LEN; p++) begin
      write_window(window_plan[p]);
      sender_burst   = (p % 3 == 1);
      receiver_burst = (p % 4 == 2);
      random_burst(HALF_PHASE);
      // Pause the sender until every result is back, then resume.
      wait_idle();
      random_burst(HALF_PHASE - 1);
      wait_idle();
    end

    if (expected_reports.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_reports.size()));
    $display("Covered %0d commands: %0d sends (%0d refused), %0d acks, %0d timeouts, %0d idle",
             items_queued, cmd_tally[CMD_SEND], sends_refused, cmd_tally[CMD_ACK],
             cmd_tally[CMD_TIMEOUT], cmd_tally[CMD_NONE]);
    $display("Window sizes 0 through 7 exercised; %0d results checked, %0d mismatches",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/srsw_pkg.sv
sv/srsw_ram.sv
sv/selective_repeat_sender_window_core.sv
tb/testbench.sv
